>>> rtl/core/yprgb_pkg.sv
// Shared types, constants and the saturating channel clip for the 4:2:2 pair to RGB converter.
// No dependencies; used by all rtl/core modules.
`default_nettype none

package yprgb_pkg;

    localparam int SUM_W = 19;  // holds every channel sum, rounding term included

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [7:0]              t_byte;

    // BT.601 studio-range coefficients, scaled by 256
    localparam t_sum K_LUMA      = 19'sd298;
    localparam t_sum K_CR_RED    = 19'sd409;
    localparam t_sum K_CB_GREEN  = 19'sd100;
    localparam t_sum K_CR_GREEN  = 19'sd208;
    localparam t_sum K_CB_BLUE   = 19'sd516;
    localparam t_sum K_ROUND     = 19'sd128;
    localparam logic signed [8:0] K_LUMA_OFS = 9'sd16;
    localparam t_byte K_CH_MAX   = 8'd255;

    // Chroma contributions shared by both lanes
    typedef struct packed {
        t_sum red;      // 409e
        t_sum green;    // 100d + 208e, subtracted by the lane
        t_sum blue;     // 516d
    } t_chroma_terms;

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
    } t_pixel;

    // Negative sums clip to 0, anything past 255 after the shift clips to 255
    function automatic t_byte clip_channel(input t_sum sum);
        t_byte res;
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (|sum[SUM_W-2:16]) begin
            res = K_CH_MAX;
        end else begin
            res = sum[15:8];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/yprgb_chroma.sv
// Shared chroma stage: removes the Cb/Cr bias and registers the three chroma products.
// Depends on yprgb_pkg.
`default_nettype none

module yprgb_chroma (
    input  wire logic                   i_clk,
    input  wire yprgb_pkg::t_byte       i_chroma_blue,
    input  wire yprgb_pkg::t_byte       i_chroma_red,
    output yprgb_pkg::t_chroma_terms    o_terms
);
    import yprgb_pkg::*;

    logic signed [7:0] w_d;
    logic signed [7:0] w_e;
    t_sum              w_d_ext;
    t_sum              w_e_ext;
    t_chroma_terms     n_terms;
    t_chroma_terms     r_terms;

    // x - 128 on an unsigned byte is just the top bit flipped
    assign w_d = $signed({~i_chroma_blue[7], i_chroma_blue[6:0]});
    assign w_e = $signed({~i_chroma_red[7], i_chroma_red[6:0]});
    assign w_d_ext = {{(SUM_W-8){w_d[7]}}, w_d};
    assign w_e_ext = {{(SUM_W-8){w_e[7]}}, w_e};

    always_comb begin
        n_terms.red   = w_e_ext * K_CR_RED;
        n_terms.green = (w_d_ext * K_CB_GREEN) + (w_e_ext * K_CR_GREEN);
        n_terms.blue  = w_d_ext * K_CB_BLUE;
    end

    always_ff @(posedge i_clk) begin
        r_terms <= n_terms;
    end

    assign o_terms = r_terms;

endmodule

`default_nettype wire

>>> rtl/core/yprgb_lane.sv
// One pixel lane: registers the luma term, then adds the chroma terms and clips each channel.
// Depends on yprgb_pkg; takes its chroma terms from yprgb_chroma.
`default_nettype none

module yprgb_lane (
    input  wire logic                   i_clk,
    input  wire yprgb_pkg::t_byte       i_luma,
    input  wire yprgb_pkg::t_chroma_terms i_terms,
    output yprgb_pkg::t_pixel           o_pixel
);
    import yprgb_pkg::*;

    logic signed [8:0] w_c;
    t_sum              w_c_ext;
    t_sum              n_base;
    t_sum              r_base;
    t_sum              w_sum_r;
    t_sum              w_sum_g;
    t_sum              w_sum_b;

    assign w_c     = $signed({1'b0, i_luma}) - K_LUMA_OFS;
    assign w_c_ext = {{(SUM_W-9){w_c[8]}}, w_c};
    assign n_base  = (w_c_ext * K_LUMA) + K_ROUND;

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
    end

    // r_base and i_terms belong to the same beat
    assign w_sum_r = r_base + i_terms.red;
    assign w_sum_g = r_base - i_terms.green;
    assign w_sum_b = r_base + i_terms.blue;

    always_comb begin
        o_pixel.red   = clip_channel(w_sum_r);
        o_pixel.green = clip_channel(w_sum_g);
        o_pixel.blue  = clip_channel(w_sum_b);
    end

endmodule

`default_nettype wire

>>> rtl/core/yuyv_pair_to_rgb.sv
// A beat is registered first in the product stage, then in the output register, where o_strobe marks it.
// Throughput: one beat per clock; busy stays low, both pixel lanes and the chroma stage pipeline.
// The pipeline is two register stages: products, then sum/clip into the output register.
// Results cannot be held off; each one is on the ports for exactly one cycle.
// Reset (synchronous, active low) clears the strobe pipeline; data registers are not reset.
// Depends on yprgb_pkg, yprgb_chroma and yprgb_lane.
`default_nettype none

module yuyv_pair_to_rgb (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire yprgb_pkg::t_byte  i_luma_first,
    input  wire yprgb_pkg::t_byte  i_luma_second,
    input  wire yprgb_pkg::t_byte  i_chroma_blue,
    input  wire yprgb_pkg::t_byte  i_chroma_red,
    input  wire logic              i_frame_end_in,
    output logic                   o_strobe,
    output yprgb_pkg::t_byte       o_first_red,
    output yprgb_pkg::t_byte       o_first_green,
    output yprgb_pkg::t_byte       o_first_blue,
    output yprgb_pkg::t_byte       o_second_red,
    output yprgb_pkg::t_byte       o_second_green,
    output yprgb_pkg::t_byte       o_second_blue,
    output logic                   o_frame_end_out
);
    import yprgb_pkg::*;

    logic          w_accept;
    t_chroma_terms w_terms;
    t_pixel        w_pix_first;
    t_pixel        w_pix_second;
    logic          r_vld_s1;
    logic          r_fe_s1;
    logic          r_strobe;
    t_pixel        r_pix_first;
    t_pixel        r_pix_second;
    logic          r_fe_out;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    yprgb_chroma u_chroma (
        .i_clk         (i_clk),
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_terms       (w_terms)
    );

    yprgb_lane u_lane_first (
        .i_clk   (i_clk),
        .i_luma  (i_luma_first),
        .i_terms (w_terms),
        .o_pixel (w_pix_first)
    );

    yprgb_lane u_lane_second (
        .i_clk   (i_clk),
        .i_luma  (i_luma_second),
        .i_terms (w_terms),
        .o_pixel (w_pix_second)
    );

    // Beat valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s1 <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld_s1 <= w_accept;
            r_strobe <= r_vld_s1;
        end
    end

    // Merge: both lanes and the frame mark land in one output register
    always_ff @(posedge i_clk) begin
        r_fe_s1      <= i_frame_end_in;
        r_fe_out     <= r_fe_s1;
        r_pix_first  <= w_pix_first;
        r_pix_second <= w_pix_second;
    end

    assign o_strobe        = r_strobe;
    assign o_first_red     = r_pix_first.red;
    assign o_first_green   = r_pix_first.green;
    assign o_first_blue    = r_pix_first.blue;
    assign o_second_red    = r_pix_second.red;
    assign o_second_green  = r_pix_second.green;
    assign o_second_blue   = r_pix_second.blue;
    assign o_frame_end_out = r_fe_out;

`ifndef SYNTHESIS
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 o_strobe)
        else $error("accepted beat did not reach the output");

    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 2))
        else $error("strobe without an accepted beat");

    a_frame_end_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_frame_end_out == $past(i_frame_end_in, 2)))
        else $error("frame end mark out of step with pixel data");

    a_pipe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_s1 |=> o_strobe)
        else $error("stage one beat lost before output");
`endif

endmodule

`default_nettype wire
